### src/nws_pkg.sv
package nws_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
    localparam int QUARTER_LEN    = 1 << QUARTER_BITS;

    localparam int STEP_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int DRAW_W  = 4;
    localparam int OUT_W   = 11;
    localparam int SINE_W  = 16;
    localparam int SUM_W   = 18;
    localparam int MAG_W   = 17;
    localparam int NOISE_W = 16;
    localparam int PROD_W  = 33;
    localparam int MIX_W   = 34;

    localparam int REM_W  = 4;
    localparam int FRAC_W = 6;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINEAR_PHASE_STEP = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_PHASE_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINEAR_GAIN       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN         = 3'd3;

    localparam int STEP_DIV = 10;
    localparam int MUL_ONE  = 10;
    localparam int MUL_23   = 23;
    localparam int MUL_57   = 57;

    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    localparam int DIV3_MUL_W  = 19;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 19'd349526;
    localparam int DIV3_SHIFT  = 20;
    localparam int DIV3_PROD_W = MAG_W + DIV3_MUL_W;

    localparam int ROUND_SHIFT = 23;
    localparam int STEP_MAX    = 512;

    localparam logic [STEP_W-1:0] LIN_STEP_RESET  = 32'd13671306;
    localparam logic [STEP_W-1:0] TURN_STEP_RESET = 32'd54685222;
    localparam logic [GAIN_W-1:0] LIN_GAIN_RESET  = 16'd59917;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RESET = 16'd14380;

    localparam logic [2:0][47:0] TURN_RESET_Q48 = {
        48'd257796772220111, 48'd79332471535257, 48'd218063015913583
    };

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [2:0][PHASE_BITS-1:0] incr_set_t;
    typedef logic [QUARTER_LEN:0][14:0] quarter_table_t;
    typedef logic [(1 << REM_W)-1:0][FRAC_W-1:0] frac_table_t;

    typedef struct packed {
        incr_set_t         lin_incr;
        incr_set_t         turn_incr;
        logic [GAIN_W-1:0] lin_gain;
        logic [GAIN_W-1:0] turn_gain;
        logic              busy;
    } cfg_state_t;

    typedef struct packed {
        logic [2:0][SINE_W-1:0] lin_sine;
        logic [2:0][SINE_W-1:0] turn_sine;
        logic                   flip_ok;
    } sine_set_t;

    typedef struct packed {
        logic ld_b;
        logic ld_c;
        logic ld_d;
    } mix_ctrl_t;

    function automatic phase_t step_phase(logic [STEP_W-1:0] step);
        logic [47:0] wide;
        wide = 48'(step);
        return wide[PHASE_BITS-1:0];
    endfunction

    function automatic phase_t incr_of(logic [STEP_W-1:0] step, int mul);
        logic [63:0] s;
        logic [63:0] prod;
        s    = 64'(step_phase(step));
        prod = (s * 64'(mul)) / 64'(STEP_DIV);
        return prod[PHASE_BITS-1:0];
    endfunction

    // Fractional part of a multiple for each remainder of the divide by ten.
    function automatic frac_table_t build_frac(int mul);
        frac_table_t tbl;
        tbl = '0;
        for (int r = 0; r < STEP_DIV; r++) begin
            tbl[r] = FRAC_W'((r * mul) / STEP_DIV);
        end
        return tbl;
    endfunction

    localparam frac_table_t FRAC_23 = build_frac(MUL_23);
    localparam frac_table_t FRAC_57 = build_frac(MUL_57);

    localparam incr_set_t LIN_INCR_RESET = {
        incr_of(LIN_STEP_RESET, MUL_57), incr_of(LIN_STEP_RESET, MUL_23),
        incr_of(LIN_STEP_RESET, MUL_ONE)
    };
    localparam incr_set_t TURN_INCR_RESET = {
        incr_of(TURN_STEP_RESET, MUL_57), incr_of(TURN_STEP_RESET, MUL_23),
        incr_of(TURN_STEP_RESET, MUL_ONE)
    };

    // Quarter-wave sine in Q15 from a Q30 Horner series through the ninth power.
    function automatic quarter_table_t build_quarter();
        quarter_table_t tbl;
        logic [63:0]    x;
        logic [63:0]    x2;
        logic [63:0]    t;
        logic [63:0]    s;
        logic [63:0]    v;
        for (int r = 0; r <= QUARTER_LEN; r++) begin
            x  = (64'(r) * HALF_PI_Q30) >> QUARTER_BITS;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            v  = (s + (64'd1 << 14)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tbl[r] = v[14:0];
        end
        return tbl;
    endfunction

    localparam quarter_table_t SINE_QUARTER = build_quarter();

    function automatic logic [SINE_W-1:0] sine_lookup(phase_t phase);
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [1:0]                quad;
        logic [QUARTER_BITS:0]     r;
        logic [14:0]               mag;
        addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        r    = {1'b0, addr[QUARTER_BITS-1:0]};
        if (quad[0]) begin
            r = (QUARTER_BITS + 1)'(QUARTER_LEN) - r;
        end
        mag = SINE_QUARTER[r];
        return quad[1] ? (SINE_W'(0) - {1'b0, mag}) : {1'b0, mag};
    endfunction

endpackage

### src/noise_wander_step_generator.sv
// Channel   Direction  Ports                                     Word
// s_        in         s_valid, s_ready, s_flip_draw             one tick, random draw
// m_        out        m_valid, m_ready, m_left/right_wheel_steps one pair of step counts
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// One word per cycle while s_ready is high; a result passes through the sine lookup,
// mean, gain multiply and round-and-saturate registers in that order.
// A write of either phase step register holds off words and further writes while the
// 2.3 and 5.7 multiples of the new step are formed.
// Reset is synchronous and active low; it loads the reset phases and configuration and clears the valids.
// A stall on m_ready backs up stage by stage; it drops s_ready only once all stages are full.
module noise_wander_step_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [nws_pkg::DRAW_W-1:0]          s_flip_draw,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [nws_pkg::OUT_W-1:0]    m_left_wheel_steps,
    output logic signed [nws_pkg::OUT_W-1:0]    m_right_wheel_steps,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nws_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nws_pkg::STEP_W-1:0]          cfg_data
);

    nws_pkg::cfg_state_t cfg_state;
    nws_pkg::sine_set_t  sines;
    nws_pkg::mix_ctrl_t  ctrl;

    logic a_v_reg;
    logic b_v_reg;
    logic c_v_reg;
    logic d_v_reg;
    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic rdy_d;
    logic accept;

    always_comb begin
        rdy_d     = !d_v_reg || m_ready;
        rdy_c     = !c_v_reg || rdy_d;
        rdy_b     = !b_v_reg || rdy_c;
        rdy_a     = !a_v_reg || rdy_b;
        s_ready   = rdy_a && !cfg_state.busy;
        accept    = s_valid && s_ready;
        ctrl.ld_b = rdy_b && a_v_reg;
        ctrl.ld_c = rdy_c && b_v_reg;
        ctrl.ld_d = rdy_d && c_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end else begin
            if (rdy_a) begin
                a_v_reg <= accept;
            end
            if (rdy_b) begin
                b_v_reg <= a_v_reg;
            end
            if (rdy_c) begin
                c_v_reg <= b_v_reg;
            end
            if (rdy_d) begin
                d_v_reg <= c_v_reg;
            end
        end
    end

    nws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_state (cfg_state)
    );

    nws_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .flip_draw (s_flip_draw),
        .lin_incr  (cfg_state.lin_incr),
        .turn_incr (cfg_state.turn_incr),
        .sines     (sines)
    );

    nws_mix u_mix (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .sines       (sines),
        .lin_gain    (cfg_state.lin_gain),
        .turn_gain   (cfg_state.turn_gain),
        .left_count  (m_left_wheel_steps),
        .right_count (m_right_wheel_steps)
    );

    assign m_valid = d_v_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cfg_state.busy) |-> $past(cfg_valid && cfg_ready))
        else $error("Divide unit started without a step register write.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> a_v_reg)
        else $error("Accepted word did not enter the lookup stage.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(c_v_reg))
        else $error("Result appeared without a word in the multiply stage.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_wheel_steps >= -11'sd512) && (m_left_wheel_steps <= 11'sd512))
        else $error("Left wheel step count outside the saturation range.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_right_wheel_steps >= -11'sd512) && (m_right_wheel_steps <= 11'sd512))
        else $error("Right wheel step count outside the saturation range.");

endmodule

### src/nws_cfg.sv
module nws_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nws_pkg::STEP_W-1:0]         cfg_data,
    output nws_pkg::cfg_state_t                cfg_state
);

    nws_pkg::incr_set_t                  lin_incr_reg;
    nws_pkg::incr_set_t                  turn_incr_reg;
    logic [nws_pkg::GAIN_W-1:0]          lin_gain_reg;
    logic [nws_pkg::GAIN_W-1:0]          turn_gain_reg;
    logic                                busy_reg;
    logic                                target_reg;
    logic                                finish_reg;
    nws_pkg::phase_t                     step_reg;
    nws_pkg::phase_t                     quot_reg;

    logic [63:0]                         recip_prod;
    nws_pkg::phase_t                     quot_next;
    nws_pkg::phase_t                     tens;
    logic [nws_pkg::REM_W-1:0]           rem;
    nws_pkg::phase_t                     incr_23;
    nws_pkg::phase_t                     incr_57;
    nws_pkg::phase_t                     step_s;
    logic                                wr;

    // The step is split into a tenth and a remainder by a reciprocal multiply; the 2.3
    // and 5.7 multiples are the scaled tenth plus a small table entry for the remainder.
    always_comb begin
        recip_prod = 64'(step_reg) * 64'(nws_pkg::RECIP10);
        quot_next  = nws_pkg::phase_t'(recip_prod >> nws_pkg::RECIP10_SHIFT);
        tens       = (quot_reg << 3) + (quot_reg << 1);
        rem        = nws_pkg::REM_W'(step_reg - tens);
        incr_23    = quot_reg * nws_pkg::phase_t'(nws_pkg::MUL_23)
                   + nws_pkg::phase_t'(nws_pkg::FRAC_23[rem]);
        incr_57    = quot_reg * nws_pkg::phase_t'(nws_pkg::MUL_57)
                   + nws_pkg::phase_t'(nws_pkg::FRAC_57[rem]);
        step_s     = nws_pkg::step_phase(cfg_data);
        wr         = cfg_valid && cfg_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_incr_reg  <= nws_pkg::LIN_INCR_RESET;
            turn_incr_reg <= nws_pkg::TURN_INCR_RESET;
            lin_gain_reg  <= nws_pkg::LIN_GAIN_RESET;
            turn_gain_reg <= nws_pkg::TURN_GAIN_RESET;
            busy_reg      <= 1'b0;
            target_reg    <= 1'b0;
            finish_reg    <= 1'b0;
        end else if (wr) begin
            unique case (cfg_index)
                nws_pkg::CFG_LINEAR_PHASE_STEP: begin
                    lin_incr_reg[0] <= step_s;
                    step_reg        <= step_s;
                    target_reg      <= 1'b0;
                    finish_reg      <= 1'b0;
                    busy_reg        <= 1'b1;
                end
                nws_pkg::CFG_TURN_PHASE_STEP: begin
                    turn_incr_reg[0] <= step_s;
                    step_reg         <= step_s;
                    target_reg       <= 1'b1;
                    finish_reg       <= 1'b0;
                    busy_reg         <= 1'b1;
                end
                nws_pkg::CFG_LINEAR_GAIN: begin
                    lin_gain_reg <= cfg_data[nws_pkg::GAIN_W-1:0];
                end
                nws_pkg::CFG_TURN_GAIN: begin
                    turn_gain_reg <= cfg_data[nws_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (busy_reg) begin
            if (!finish_reg) begin
                quot_reg   <= quot_next;
                finish_reg <= 1'b1;
            end else begin
                busy_reg   <= 1'b0;
                finish_reg <= 1'b0;
                if (target_reg) begin
                    turn_incr_reg[1] <= incr_23;
                    turn_incr_reg[2] <= incr_57;
                end else begin
                    lin_incr_reg[1] <= incr_23;
                    lin_incr_reg[2] <= incr_57;
                end
            end
        end
    end

    assign cfg_ready           = !busy_reg;
    assign cfg_state.lin_incr  = lin_incr_reg;
    assign cfg_state.turn_incr = turn_incr_reg;
    assign cfg_state.lin_gain  = lin_gain_reg;
    assign cfg_state.turn_gain = turn_gain_reg;
    assign cfg_state.busy      = busy_reg;

endmodule

### src/nws_phase.sv
module nws_phase (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [nws_pkg::DRAW_W-1:0]    flip_draw,
    input  nws_pkg::incr_set_t            lin_incr,
    input  nws_pkg::incr_set_t            turn_incr,
    output nws_pkg::sine_set_t            sines
);

    nws_pkg::incr_set_t lin_phase_reg;
    nws_pkg::incr_set_t turn_phase_reg;
    nws_pkg::sine_set_t sines_reg;
    nws_pkg::sine_set_t sines_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sines_next.lin_sine[i]  = nws_pkg::sine_lookup(lin_phase_reg[i]);
            sines_next.turn_sine[i] = nws_pkg::sine_lookup(turn_phase_reg[i]);
        end
        sines_next.flip_ok = (flip_draw == '0);
    end

    // The word uses the phases held before this tick; all six advance together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_phase_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                turn_phase_reg[i] <=
                    nws_pkg::TURN_RESET_Q48[i][47 -: nws_pkg::PHASE_BITS];
            end
        end else if (advance) begin
            for (int i = 0; i < 3; i++) begin
                lin_phase_reg[i]  <= lin_phase_reg[i] + lin_incr[i];
                turn_phase_reg[i] <= turn_phase_reg[i] + turn_incr[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sines_reg <= sines_next;
        end
    end

    assign sines = sines_reg;

endmodule

### src/nws_mix.sv
module nws_mix (
    input  logic                                aclk,
    input  nws_pkg::mix_ctrl_t                  ctrl,
    input  nws_pkg::sine_set_t                  sines,
    input  logic [nws_pkg::GAIN_W-1:0]          lin_gain,
    input  logic [nws_pkg::GAIN_W-1:0]          turn_gain,
    output logic signed [nws_pkg::OUT_W-1:0]    left_count,
    output logic signed [nws_pkg::OUT_W-1:0]    right_count
);

    logic signed [nws_pkg::NOISE_W-1:0] lin_noise_reg;
    logic signed [nws_pkg::NOISE_W-1:0] turn_noise_reg;
    logic signed [nws_pkg::PROD_W-1:0]  lin_prod_reg;
    logic signed [nws_pkg::PROD_W-1:0]  turn_prod_reg;
    logic signed [nws_pkg::OUT_W-1:0]   left_reg;
    logic signed [nws_pkg::OUT_W-1:0]   right_reg;

    logic signed [nws_pkg::NOISE_W-1:0] lin_noise_next;
    logic signed [nws_pkg::NOISE_W-1:0] lin_noise_mean;
    logic signed [nws_pkg::NOISE_W-1:0] turn_noise_next;
    logic signed [nws_pkg::PROD_W-1:0]  lin_prod_next;
    logic signed [nws_pkg::PROD_W-1:0]  turn_prod_next;
    logic signed [nws_pkg::MIX_W-1:0]   diff;
    logic signed [nws_pkg::MIX_W-1:0]   total;

    // Mean of three sines, rounded half away from zero; the divide by three
    // is a multiply by a scaled reciprocal that is exact over this range.
    function automatic logic signed [nws_pkg::NOISE_W-1:0] mean3(
        logic [2:0][nws_pkg::SINE_W-1:0] s
    );
        logic signed [nws_pkg::SUM_W-1:0]   sum;
        logic signed [nws_pkg::SUM_W-1:0]   neg;
        logic [nws_pkg::MAG_W-1:0]          n;
        logic [nws_pkg::DIV3_PROD_W-1:0]    prod;
        logic [nws_pkg::NOISE_W-1:0]        q;
        sum  = nws_pkg::SUM_W'($signed(s[0])) + nws_pkg::SUM_W'($signed(s[1]))
             + nws_pkg::SUM_W'($signed(s[2]));
        neg  = -sum;
        n    = sum[nws_pkg::SUM_W-1] ? nws_pkg::MAG_W'(neg) : nws_pkg::MAG_W'(sum);
        n    = n + nws_pkg::MAG_W'(1);
        prod = nws_pkg::DIV3_PROD_W'(n) * nws_pkg::DIV3_PROD_W'(nws_pkg::DIV3_MUL);
        q    = nws_pkg::NOISE_W'(prod >> nws_pkg::DIV3_SHIFT);
        return sum[nws_pkg::SUM_W-1] ? $signed(nws_pkg::NOISE_W'(0) - q) : $signed(q);
    endfunction

    function automatic logic signed [nws_pkg::OUT_W-1:0] to_steps(
        logic signed [nws_pkg::MIX_W-1:0] v
    );
        logic [nws_pkg::MIX_W-1:0] mag;
        logic [nws_pkg::MIX_W-1:0] rnd;
        logic [nws_pkg::OUT_W-1:0] m;
        mag = v[nws_pkg::MIX_W-1] ? nws_pkg::MIX_W'(-v) : nws_pkg::MIX_W'(v);
        rnd = (mag + (nws_pkg::MIX_W'(1) << (nws_pkg::ROUND_SHIFT - 1)))
            >> nws_pkg::ROUND_SHIFT;
        m   = (rnd > nws_pkg::MIX_W'(nws_pkg::STEP_MAX)) ? nws_pkg::OUT_W'(nws_pkg::STEP_MAX)
                                                          : rnd[nws_pkg::OUT_W-1:0];
        return v[nws_pkg::MIX_W-1] ? $signed(nws_pkg::OUT_W'(0) - m) : $signed(m);
    endfunction

    always_comb begin
        lin_noise_mean  = mean3(sines.lin_sine);
        turn_noise_next = mean3(sines.turn_sine);
        lin_noise_next  = (sines.flip_ok && lin_noise_mean > 0) ? -lin_noise_mean
                                                                : lin_noise_mean;
        lin_prod_next   = $signed({1'b0, lin_gain}) * lin_noise_reg;
        turn_prod_next  = $signed({1'b0, turn_gain}) * turn_noise_reg;
        diff            = nws_pkg::MIX_W'(lin_prod_reg) - nws_pkg::MIX_W'(turn_prod_reg);
        total           = nws_pkg::MIX_W'(lin_prod_reg) + nws_pkg::MIX_W'(turn_prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_b) begin
            lin_noise_reg  <= lin_noise_next;
            turn_noise_reg <= turn_noise_next;
        end
        if (ctrl.ld_c) begin
            lin_prod_reg  <= lin_prod_next;
            turn_prod_reg <= turn_prod_next;
        end
        if (ctrl.ld_d) begin
            left_reg  <= to_steps(diff);
            right_reg <= to_steps(total);
        end
    end

    assign left_count  = left_reg;
    assign right_count = right_reg;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PH_W            = nws_pkg::PHASE_BITS;
    localparam int ADDR_W          = nws_pkg::SINE_ADDR_BITS;
    localparam int IDX_W           = nws_pkg::CFG_INDEX_W;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RANDOM_PHASES   = 6;
    localparam int TICKS_PER_PHASE = 170;
    localparam int SCRIPT_ROWS     = 31;
    localparam int IDLE_PERCENT    = 12;
    localparam int FLIP_DRAW       = 0;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint WHEEL_LIMIT          = 512;
    localparam logic [IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef logic [PH_W-1:0] phase_t;
    typedef logic signed [nws_pkg::OUT_W-1:0] wheel_t;
    typedef logic [nws_pkg::DRAW_W-1:0] draw_t;
    typedef logic [nws_pkg::STEP_W-1:0] reg_data_t;

    typedef struct packed {
        wheel_t left;
        wheel_t right;
    } wheel_pair_t;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] index;
        reg_data_t        data;
        draw_t            draw;
        logic             known;
        wheel_t           left;
        wheel_t           right;
    } script_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    draw_t            s_flip_draw = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    wheel_t           m_left_wheel_steps;
    wheel_t           m_right_wheel_steps;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    reg_data_t        cfg_data = '0;

    phase_t      lin_phase [3];
    phase_t      turn_phase [3];
    reg_data_t   lin_step_q;
    reg_data_t   turn_step_q;
    logic [15:0] lin_gain_q;
    logic [15:0] turn_gain_q;

    wheel_pair_t pending_wheels [$];
    script_row_t script [SCRIPT_ROWS];
    bit          calm = 1'b0;
    int          errors = 0;
    int          checked_words = 0;
    int          ticks_sent = 0;
    int          writes_done = 0;

    noise_wander_step_generator u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_flip_draw         (s_flip_draw),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_left_wheel_steps  (m_left_wheel_steps),
        .m_right_wheel_steps (m_right_wheel_steps),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic int sine_q15(longint unsigned addr);
        longint unsigned quarter;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        quarter = 64'd1 << (ADDR_W - 2);
        quad    = (addr >> (ADDR_W - 2)) & 64'd3;
        r       = addr & (quarter - 64'd1);
        if (quad[0]) begin
            r = quarter - r;
        end
        x  = (r * HALF_PI_Q30) >> (ADDR_W - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        v  = (s + (64'd1 << 14)) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? -int'(v) : int'(v);
    endfunction

    function automatic int mean_noise(phase_t a, phase_t b, phase_t c);
        int sum;
        sum = sine_q15(longint'(a >> (PH_W - ADDR_W)))
            + sine_q15(longint'(b >> (PH_W - ADDR_W)))
            + sine_q15(longint'(c >> (PH_W - ADDR_W)));
        if (sum >= 0) begin
            return (sum + 1) / 3;
        end
        return -((-sum + 1) / 3);
    endfunction

    function automatic phase_t phase_incr(reg_data_t step, int k);
        longint unsigned s;
        longint unsigned ratio;
        s     = longint'(phase_t'(step));
        ratio = (k == 0) ? 64'd10 : ((k == 1) ? 64'd23 : 64'd57);
        return phase_t'((s * ratio) / 64'd10);
    endfunction

    function automatic wheel_t round_wheel(longint q23);
        longint mag;
        longint v;
        mag = (q23 < 0) ? -q23 : q23;
        v   = (mag + (64'sd1 <<< 22)) >>> 23;
        if (v > WHEEL_LIMIT) begin
            v = WHEEL_LIMIT;
        end
        if (q23 < 0) begin
            v = -v;
        end
        return wheel_t'(v);
    endfunction

    task automatic reset_model();
        lin_step_q  = nws_pkg::LIN_STEP_RESET;
        turn_step_q = nws_pkg::TURN_STEP_RESET;
        lin_gain_q  = nws_pkg::LIN_GAIN_RESET;
        turn_gain_q = nws_pkg::TURN_GAIN_RESET;
        for (int k = 0; k < 3; k++) begin
            lin_phase[k] = '0;
        end
        turn_phase[0] = phase_t'(64'd218063015913583 >> (48 - PH_W));
        turn_phase[1] = phase_t'(64'd79332471535257 >> (48 - PH_W));
        turn_phase[2] = phase_t'(64'd257796772220111 >> (48 - PH_W));
    endtask

    task automatic predict_wheels(input draw_t draw, output wheel_pair_t w);
        int     n_lin;
        int     n_turn;
        longint lin;
        longint turn;
        n_lin  = mean_noise(lin_phase[0], lin_phase[1], lin_phase[2]);
        n_turn = mean_noise(turn_phase[0], turn_phase[1], turn_phase[2]);
        if (draw == draw_t'(FLIP_DRAW) && n_lin > 0) begin
            n_lin = -n_lin;
        end
        lin     = longint'(lin_gain_q) * longint'(n_lin);
        turn    = longint'(turn_gain_q) * longint'(n_turn);
        w.left  = round_wheel(lin - turn);
        w.right = round_wheel(lin + turn);
        for (int k = 0; k < 3; k++) begin
            lin_phase[k]  = lin_phase[k] + phase_incr(lin_step_q, k);
            turn_phase[k] = turn_phase[k] + phase_incr(turn_step_q, k);
        end
    endtask

    task automatic apply_write(input logic [IDX_W-1:0] idx, input reg_data_t data);
        case (idx)
            nws_pkg::CFG_LINEAR_PHASE_STEP: lin_step_q = data;
            nws_pkg::CFG_TURN_PHASE_STEP:   turn_step_q = data;
            nws_pkg::CFG_LINEAR_GAIN:       lin_gain_q = data[15:0];
            nws_pkg::CFG_TURN_GAIN:         turn_gain_q = data[15:0];
            default: ;
        endcase
    endtask

    function automatic script_row_t tick_row(draw_t d, logic known);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_TICK;
        row.draw  = d;
        row.known = known;
        return row;
    endfunction

    function automatic script_row_t write_row(logic [IDX_W-1:0] idx, reg_data_t data);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.data  = data;
        return row;
    endfunction

    task automatic send_tick(input draw_t d, input logic known, input wheel_t left,
                             input wheel_t right);
        wheel_pair_t w;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_flip_draw <= d;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_wheels(d, w);
        if (known) begin
            w.left  = left;
            w.right = right;
        end
        pending_wheels.push_back(w);
        ticks_sent++;
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input reg_data_t data,
                             input logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        apply_write(idx, data);
        writes_done++;
        if (last) begin
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_wheels.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic reg_data_t random_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return reg_data_t'($urandom_range(0, 32'h0200_0000));
            default: return reg_data_t'($urandom);
        endcase
    endfunction

    function automatic reg_data_t random_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return reg_data_t'(16'hFFFF);
            2:       return reg_data_t'($urandom);
            default: return reg_data_t'($urandom_range(0, 65535));
        endcase
    endfunction

    always @(posedge aclk) begin : result_check
        wheel_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_wheels.size() == 0) begin
                $display("%0t: unexpected word, left %0d right %0d", $time,
                         m_left_wheel_steps, m_right_wheel_steps);
                errors++;
            end else begin
                want = pending_wheels.pop_front();
                checked_words++;
                if (m_left_wheel_steps !== want.left) begin
                    $display("%0t: left wheel expected %0d, actual %0d", $time,
                             want.left, m_left_wheel_steps);
                    errors++;
                end
                if (m_right_wheel_steps !== want.right) begin
                    $display("%0t: right wheel expected %0d, actual %0d", $time,
                             want.right, m_right_wheel_steps);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout", $time);
        $display("noise_wander_step_generator test failed");
        $finish;
    end

    initial begin
        int          pause_at;
        int          drain_cycles;
        logic        next_is_write;
        script_row_t row;

        script = '{
            tick_row(4'd0, 1'b0), tick_row(4'd9, 1'b0), tick_row(4'd15, 1'b0),
            tick_row(4'd0, 1'b0), tick_row(4'd8, 1'b0), tick_row(4'd4, 1'b0),
            tick_row(4'd2, 1'b0), tick_row(4'd1, 1'b0), tick_row(4'd10, 1'b0),
            tick_row(4'd0, 1'b0),
            write_row(nws_pkg::CFG_LINEAR_GAIN, 32'd0),
            write_row(nws_pkg::CFG_TURN_GAIN, 32'd0),
            tick_row(4'd0, 1'b1), tick_row(4'd5, 1'b1),
            write_row(nws_pkg::CFG_LINEAR_PHASE_STEP, 32'hFFFF_FFFF),
            write_row(nws_pkg::CFG_TURN_PHASE_STEP, 32'hFFFF_FFFF),
            write_row(nws_pkg::CFG_LINEAR_GAIN, 32'hFFFF_FFFF),
            write_row(nws_pkg::CFG_TURN_GAIN, 32'hFFFF_FFFF),
            tick_row(4'd0, 1'b0), tick_row(4'd3, 1'b0), tick_row(4'd0, 1'b0),
            tick_row(4'd7, 1'b0), tick_row(4'd15, 1'b0),
            write_row(CFG_SPARE_FIRST, 32'h1234_5678),
            write_row(CFG_SPARE_LAST, 32'hFFFF_FFFF),
            write_row(nws_pkg::CFG_LINEAR_PHASE_STEP, 32'h4000_0000),
            write_row(nws_pkg::CFG_TURN_PHASE_STEP, 32'd0),
            tick_row(4'd0, 1'b0), tick_row(4'd1, 1'b0), tick_row(4'd0, 1'b0),
            tick_row(4'd6, 1'b0)
        };

        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            row = script[i];
            if (row.kind == ROW_TICK) begin
                send_tick(row.draw, row.known, row.left, row.right);
            end else begin
                if (i == 0 || script[i - 1].kind != ROW_WRITE) begin
                    settle_idle();
                end
                next_is_write = (i + 1 < SCRIPT_ROWS) && (script[i + 1].kind == ROW_WRITE);
                reg_write(row.index, row.data, !next_is_write);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle_idle();
            calm = (p == 2);
            if ($urandom_range(0, 2) == 0) begin
                reg_write(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom, 1'b0);
            end
            reg_write(nws_pkg::CFG_LINEAR_PHASE_STEP, random_step(), 1'b0);
            reg_write(nws_pkg::CFG_TURN_PHASE_STEP, random_step(), 1'b0);
            reg_write(nws_pkg::CFG_LINEAR_GAIN, random_gain(), 1'b0);
            reg_write(nws_pkg::CFG_TURN_GAIN, random_gain(), 1'b1);
            pause_at = $urandom_range(20, TICKS_PER_PHASE - 20);
            for (int i = 0; i < TICKS_PER_PHASE; i++) begin
                if (i == pause_at) begin
                    settle_idle();
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_tick(draw_t'(FLIP_DRAW), 1'b0, '0, '0);
                end else begin
                    send_tick(draw_t'($urandom_range(0, 15)), 1'b0, '0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        calm = 1'b0;
        drain_cycles = 0;
        while (pending_wheels.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_wheels.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, pending_wheels.size());
            errors += pending_wheels.size();
        end

        $display("Sent %0d ticks with draws 0 to 15 and checked %0d step pairs.",
                 ticks_sent, checked_words);
        $display("Made %0d register writes, zero and full-scale steps and gains included.",
                 writes_done);
        if (errors == 0) begin
            $display("noise_wander_step_generator test passed");
        end else begin
            $display("noise_wander_step_generator test failed");
        end
        $finish;
    end

endmodule
